// ----- hw/rtl/lwub_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the longest-window-under-budget block.
// No dependencies; every other file takes what it needs from here by scoped names.
package lwub_pkg;

  // Sequence capacity and derived widths
  localparam int MAX_ITEMS = 4096;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int DATA_W    = 16;
  localparam int SUM_W     = DATA_W + ADDR_W + 1;
  localparam int BUDGET_W  = 30;
  localparam int LEN_W     = 13;

  // Window store access request from the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- hw/rtl/lwub_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input elements, results and the budget write.
// Depends on lwub_pkg for field widths.
interface lwub_item_if;
  logic                          valid;
  logic                          ready;
  logic [lwub_pkg::DATA_W-1:0]   element;
  logic                          is_last;
  modport source (output valid, element, is_last, input ready);
  modport sink   (input valid, element, is_last, output ready);
endinterface

interface lwub_result_if;
  logic                          valid;
  logic                          ready;
  logic [lwub_pkg::LEN_W-1:0]    longest;
  logic                          overflow;
  modport source (output valid, longest, overflow, input ready);
  modport sink   (input valid, longest, overflow, output ready);
endinterface

interface lwub_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lwub_pkg::BUDGET_W-1:0] budget;
  modport source (output valid, budget, input ready);
  modport sink   (input valid, budget, output ready);
endinterface

// ----- hw/rtl/lwub_store.sv -----
`timescale 1ns / 1ps
// Window store: single-write, single-read synchronous RAM with a registered read.
// Depends on lwub_pkg for depth, widths and the request struct.
module lwub_store (
  input  logic                        clk,
  input  lwub_pkg::mem_req_t          req,
  output logic [lwub_pkg::DATA_W-1:0] rdata
);

  logic [lwub_pkg::DATA_W-1:0] mem [lwub_pkg::MAX_ITEMS];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ----- hw/rtl/lwub_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: appends elements, retires the oldest while over budget, tracks best length.
// Depends on lwub_pkg, lwub_if; drives the window store through a mem_req_t.
module lwub_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  lwub_item_if.sink                   items,
  lwub_result_if.source               results,
  lwub_cfg_if.sink                    cfg,
  output lwub_pkg::mem_req_t          mem_req,
  input  logic [lwub_pkg::DATA_W-1:0] mem_rdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_SUB   = 2'd2;

  logic [1:0]                    state;
  logic [lwub_pkg::CNT_W-1:0]    count;
  logic [lwub_pkg::CNT_W-1:0]    head;
  logic [lwub_pkg::SUM_W-1:0]    sum;
  logic [lwub_pkg::CNT_W-1:0]    best;
  logic                          ovf;
  logic                          last_q;
  logic                          pop_en;
  logic [lwub_pkg::BUDGET_W-1:0] budget;
  logic                          res_valid;
  logic [lwub_pkg::LEN_W-1:0]    res_longest;
  logic                          res_overflow;

  logic                          accept;
  logic                          full;
  logic                          over;
  logic                          do_pop;
  logic [lwub_pkg::CNT_W-1:0]    win_len;
  logic [lwub_pkg::CNT_W-1:0]    best_next;
  logic                          out_free;
  logic                          publish;

  assign accept   = items.valid && items.ready;
  assign full     = (count == lwub_pkg::CNT_W'(lwub_pkg::MAX_ITEMS));
  assign over     = (lwub_pkg::BUDGET_W'(sum) > budget);
  assign do_pop   = pop_en && over && (head < count);
  assign win_len  = count - head;
  assign best_next = (win_len > best) ? win_len : best;
  assign out_free = !res_valid || results.ready;
  assign publish  = (state == ST_CHECK) && !do_pop && last_q && out_free;

  // Handshake outputs
  assign items.ready      = (state == ST_IDLE);
  assign cfg.ready        = 1'b1;
  assign results.valid    = res_valid;
  assign results.longest  = res_longest;
  assign results.overflow = res_overflow;

  // Store requests: append on accept unless full, fetch oldest when retiring
  always_comb begin
    mem_req.we    = (state == ST_IDLE) && accept && !full;
    mem_req.waddr = count[lwub_pkg::ADDR_W-1:0];
    mem_req.wdata = items.element;
    mem_req.re    = (state == ST_CHECK) && do_pop;
    mem_req.raddr = head[lwub_pkg::ADDR_W-1:0];
  end

  // Budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (cfg.valid && cfg.ready) begin
      budget <= cfg.budget;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (publish) begin
      res_longest  <= lwub_pkg::LEN_W'(best_next);
      res_overflow <= ovf;
    end
  end

  // Result valid: set on publish, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (publish) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      head      <= '0;
      sum       <= '0;
      best      <= '0;
      ovf       <= 1'b0;
      last_q    <= 1'b0;
      pop_en    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            last_q <= items.is_last;
            if (!full) begin
              count  <= count + 1'b1;
              sum    <= sum + lwub_pkg::SUM_W'(items.element);
              pop_en <= 1'b1;
              state  <= ST_CHECK;
            end else begin
              ovf    <= 1'b1;
              pop_en <= 1'b0;
              if (items.is_last) begin
                state <= ST_CHECK;
              end
            end
          end
        end
        ST_CHECK: begin
          if (do_pop) begin
            head  <= head + 1'b1;
            state <= ST_SUB;
          end else if (!last_q) begin
            best  <= best_next;
            state <= ST_IDLE;
          end else if (out_free) begin
            // end of sequence: publish and clear
            count     <= '0;
            head      <= '0;
            sum       <= '0;
            best      <= '0;
            ovf       <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        ST_SUB: begin
          sum   <= sum - lwub_pkg::SUM_W'(mem_rdata);
          state <= ST_CHECK;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/longest_window_under_budget.sv -----
`timescale 1ns / 1ps
// Longest window under budget, top level. Each accepted element, unless the store is full, is
// added to the window; then the oldest is retired while over budget, by a store read and then a subtract.
// An element is taken only once the previous one is through; an ignored non-last element
// (store full) leaves the block ready for the next. The result is registered after the last
// element, and is held back while the previous result still waits to be taken.
// Reset (rst, synchronous) clears sequence state and budget; the store is not cleared.
module longest_window_under_budget (
  input  logic          clk,
  input  logic          rst,
  lwub_item_if.sink     items,
  lwub_result_if.source results,
  lwub_cfg_if.sink      cfg
);

  lwub_pkg::mem_req_t          mem_req;
  logic [lwub_pkg::DATA_W-1:0] mem_rdata;

  lwub_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  lwub_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

`ifndef SYNTHESIS
  // Store writes happen only for accepted requests
  assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (items.valid && items.ready))
    else $error("store write without accepted request");

  // Append and retire never share a cycle
  assert property (@(posedge clk) disable iff (rst)
    !(mem_req.we && mem_req.re))
    else $error("store read and write in the same cycle");

  // A reported length never exceeds the sequence capacity
  assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.longest <= lwub_pkg::LEN_W'(lwub_pkg::MAX_ITEMS)))
    else $error("longest exceeds capacity");
`endif

endmodule

// ----- sim/longest_window_under_budget_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for longest_window_under_budget: drives element sequences and budget
// writes, predicts each sequence's best window length and overflow, checks every result.
// Depends on lwub_pkg, the lwub_*_if interfaces and the RTL top level.
module longest_window_under_budget_test;

  localparam int STALL_LIMIT = 40000;  // cycles with no handshake before giving up

  typedef struct {
    logic [lwub_pkg::LEN_W-1:0] longest;
    logic                       overflow;
  } window_result_t;

  logic clk = 1'b0;
  logic rst;

  lwub_item_if   items_if ();
  lwub_result_if results_if ();
  lwub_cfg_if    cfg_if ();

  longest_window_under_budget uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always #5 clk = ~clk;

  // Predictor state, mirrors the sequence state of the block
  logic [lwub_pkg::DATA_W-1:0]   window_copy [lwub_pkg::MAX_ITEMS];
  logic [lwub_pkg::CNT_W-1:0]    seq_count;
  logic [lwub_pkg::CNT_W-1:0]    win_head;
  logic [lwub_pkg::SUM_W-1:0]    win_sum;
  logic [lwub_pkg::LEN_W-1:0]    best_len;
  logic                          seq_overflow;
  logic [lwub_pkg::BUDGET_W-1:0] budget_now;
  int                            last_retires;

  window_result_t pending_results [$];
  window_result_t got_expected;

  int   send_idle_pct;
  int   recv_idle_pct;
  logic results_held = 1'b0;
  int   failures = 0;
  int   elements_sent;
  int   sequences_sent;
  int   budget_writes;
  int   results_checked = 0;
  int   idle_run = 0;

  // Apply one accepted element to the predicted window
  task automatic predict_window(input logic [lwub_pkg::DATA_W-1:0] elem, input logic last);
    window_result_t res;
    last_retires = 0;
    if (seq_count < lwub_pkg::CNT_W'(lwub_pkg::MAX_ITEMS)) begin
      window_copy[seq_count[lwub_pkg::ADDR_W-1:0]] = elem;
      seq_count = seq_count + 1'b1;
      win_sum = win_sum + elem;
      // shrink from the oldest end until the window fits
      while ((lwub_pkg::SUM_W + 1)'(win_sum) > (lwub_pkg::SUM_W + 1)'(budget_now) &&
             win_head < seq_count) begin
        win_sum = win_sum - window_copy[win_head[lwub_pkg::ADDR_W-1:0]];
        win_head = win_head + 1'b1;
        last_retires++;
      end
      if (lwub_pkg::LEN_W'(seq_count - win_head) > best_len)
        best_len = lwub_pkg::LEN_W'(seq_count - win_head);
    end else begin
      seq_overflow = 1'b1;
    end
    if (last) begin
      res.longest  = best_len;
      res.overflow = seq_overflow;
      pending_results.push_back(res);
      seq_count    = '0;
      win_head     = '0;
      win_sum      = '0;
      best_len     = '0;
      seq_overflow = 1'b0;
      sequences_sent++;
    end
  endtask

  // One element request; valid stays high afterwards for back-to-back requests
  task automatic send_element(input logic [lwub_pkg::DATA_W-1:0] elem, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid   <= 1'b1;
    items_if.element <= elem;
    items_if.is_last <= last;
    @(posedge clk);
    while (!items_if.ready) @(posedge clk);
    predict_window(elem, last);
    elements_sent++;
  endtask

  // Budget write once the block has gone quiet
  task automatic write_budget(input logic [lwub_pkg::BUDGET_W-1:0] value);
    items_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 + 2 * last_retires) @(posedge clk);
    cfg_if.valid  <= 1'b1;
    cfg_if.budget <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    budget_now = value;
    budget_writes++;
  endtask

  function automatic logic [lwub_pkg::BUDGET_W-1:0] random_budget();
    logic [31:0] r;
    r = $urandom();
    unique case ($urandom_range(0, 5))
      0: return '0;
      1: return lwub_pkg::BUDGET_W'($urandom_range(0, 255));
      2: return lwub_pkg::BUDGET_W'($urandom_range(256, 65535));
      3: return lwub_pkg::BUDGET_W'($urandom_range(65536, 1 << 20));
      4: return '1;
      default: return r[lwub_pkg::BUDGET_W-1:0];
    endcase
  endfunction

  // Random sequence; element magnitude picked per sequence, rare budget change mid-way
  task automatic send_random_sequence(output int len);
    logic [lwub_pkg::DATA_W-1:0] mask;
    logic [31:0]                 r;
    mask = lwub_pkg::DATA_W'((32'd1 << (4 * $urandom_range(1, 4))) - 1);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 39) == 0)
        write_budget(random_budget());
      r = $urandom();
      send_element(r[lwub_pkg::DATA_W-1:0] & mask, i == len - 1);
    end
  endtask

  // Budget left at its reset value of zero: only zero-cost elements fit
  task automatic test_reset_budget();
    send_element(16'd0, 1'b0);
    send_element(16'd0, 1'b0);
    send_element(16'hFFFF, 1'b1);
  endtask

  // Short sequences at budget 100, one element above it, then at the all-ones budget
  task automatic test_directed_windows();
    write_budget(lwub_pkg::BUDGET_W'(100));
    send_element(16'd30, 1'b0);
    send_element(16'd40, 1'b0);
    send_element(16'd50, 1'b1);
    send_element(16'hFFFF, 1'b1);
    send_element(16'd10, 1'b0);
    send_element(16'd20, 1'b0);
    send_element(16'd200, 1'b0);
    send_element(16'd30, 1'b0);
    send_element(16'd40, 1'b0);
    send_element(16'd50, 1'b1);
    write_budget('1);
    repeat (3) send_element(16'hFFFF, 1'b0);
    send_element(16'hFFFF, 1'b1);
  endtask

  // New budget lands between two elements of one sequence
  task automatic test_midsequence_budget();
    write_budget(lwub_pkg::BUDGET_W'(100));
    send_element(16'd50, 1'b0);
    send_element(16'd50, 1'b0);
    write_budget(lwub_pkg::BUDGET_W'(40));
    send_element(16'd10, 1'b1);
  endtask

  // Full store: longest retirement run, window emptied, then ignored elements
  task automatic test_capacity();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    write_budget('0);
    for (int i = 0; i < lwub_pkg::MAX_ITEMS - 1; i++) send_element(16'd0, 1'b0);
    send_element(16'd1, 1'b0);
    send_element(16'd7, 1'b0);
    send_element(16'd3, 1'b1);
  endtask

  // Results held back for a long stretch while sequences keep coming
  task automatic test_result_backpressure();
    send_idle_pct = 0;
    write_budget(lwub_pkg::BUDGET_W'(1000));
    fork
      begin
        results_held <= 1'b1;
        repeat (400) @(posedge clk);
        results_held <= 1'b0;
      end
      begin
        for (int s = 0; s < 10; s++) begin
          send_element(lwub_pkg::DATA_W'($urandom_range(0, 900)), 1'b0);
          send_element(lwub_pkg::DATA_W'($urandom_range(0, 900)), 1'b1);
        end
      end
    join
  endtask

  // Random sequences over three idling patterns and several budgets each
  task automatic test_random_traffic();
    int len;
    int phase_items;
    for (int mode = 0; mode < 3; mode++) begin
      unique case (mode)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < 5; p++) begin
        if (p == 0)
          write_budget('0);
        else if (p == 1)
          write_budget('1);
        else
          write_budget(random_budget());
        phase_items = 0;
        while (phase_items < 115) begin
          send_random_sequence(len);
          phase_items += len;
        end
      end
    end
  endtask

  // Result side: check each accepted result, then pick the next ready
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: longest %0d overflow %0b",
                 results_if.longest, results_if.overflow);
          failures++;
        end else begin
          got_expected = pending_results.pop_front();
          results_checked++;
          if (results_if.longest !== got_expected.longest) begin
            $error("longest: expected %0d, actual %0d", got_expected.longest,
                   results_if.longest);
            failures++;
          end
          if (results_if.overflow !== got_expected.overflow) begin
            $error("overflow: expected %0b, actual %0b", got_expected.overflow,
                   results_if.overflow);
            failures++;
          end
        end
      end
      results_if.ready <= !results_held && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("longest_window_under_budget_test failed");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    items_if.valid   <= 1'b0;
    items_if.element <= '0;
    items_if.is_last <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.budget    <= '0;
    seq_count     = '0;
    win_head      = '0;
    win_sum       = '0;
    best_len      = '0;
    seq_overflow  = 1'b0;
    budget_now    = '0;
    last_retires  = 0;
    elements_sent = 0;
    sequences_sent = 0;
    budget_writes = 0;
    send_idle_pct = 36;
    recv_idle_pct = 58;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_budget();
    test_directed_windows();
    test_midsequence_budget();
    test_capacity();
    test_result_backpressure();
    test_random_traffic();

    items_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run: %0d elements in %0d sequences, %0d budget writes, %0d results checked.",
             elements_sent, sequences_sent, budget_writes, results_checked);
    $display("Covered full-store retirement, ignored elements, mid-sequence budget change, "
             , "result back-pressure and three idling patterns.");
    if (failures == 0)
      $display("longest_window_under_budget_test passed");
    else
      $display("longest_window_under_budget_test failed");
    $finish;
  end

endmodule
